### rtl/r2h_pkg.sv
// Shared types, widths and divider step functions for the RGB to HSV converter.
package r2h_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned FRAC_W = 16;
    // Widest dividend: 2*num*65535 + 6*d with num < 6*d, d <= 255
    localparam int unsigned NUM_W  = 28;
    // Widest divisor: 12*d
    localparam int unsigned REM_W  = 12;
    // Quotient bits, one above the 16-bit result so rounding can overflow safely
    localparam int unsigned Q_W    = FRAC_W + 1;

    localparam int unsigned DIV_STEPS           = Q_W;
    localparam int unsigned DIV_STEPS_PER_STAGE = 3;
    localparam int unsigned DIV_STAGES          =
        (DIV_STEPS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [FRAC_W-1:0] hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] brightness;
    } hsv_t;

    // One restoring-division lane: partial remainder, dividend bits still to
    // shift in (which fill with quotient bits from the bottom) and divisor.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   acc;
        logic [REM_W-1:0] den;
    } lane_t;

    typedef struct packed {
        lane_t           sat;
        lane_t           hue;
        logic [CH_W-1:0] mx;
    } div_item_t;

    // Quotient is known to fit in Q_W bits, so the top dividend bits are
    // already below the divisor and form the starting remainder.
    function automatic lane_t lane_init(logic [NUM_W-1:0] num, logic [REM_W-1:0] den);
        lane_t x;
        x.rem = REM_W'(num[NUM_W-1:Q_W]);
        x.acc = num[Q_W-1:0];
        x.den = den;
        return x;
    endfunction

    function automatic lane_t div_step(lane_t x);
        lane_t          y;
        logic [REM_W:0] t;
        logic [REM_W:0] diff;
        y    = x;
        t    = {x.rem, x.acc[Q_W-1]};
        diff = t - {1'b0, x.den};
        if (t >= {1'b0, x.den})
        begin
            y.rem = diff[REM_W-1:0];
            y.acc = {x.acc[Q_W-2:0], 1'b1};
        end
        else
        begin
            y.rem = t[REM_W-1:0];
            y.acc = {x.acc[Q_W-2:0], 1'b0};
        end
        return y;
    endfunction

    function automatic logic [FRAC_W-1:0] clamp16(logic [Q_W-1:0] q);
        logic [FRAC_W-1:0] r;
        if (q[Q_W-1:FRAC_W] != '0)
        begin
            r = '1;
        end
        else
        begin
            r = q[FRAC_W-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/rgb8_to_hsv16_converter_core.sv
// Top level of the 8-bit RGB to 16-bit HSV converter.
// Converts one RGB pixel per clock, when the output is not stalled, into hue,
// saturation and value, each a 16-bit fraction; hue and saturation come from
// exact round-half-up division. A pixel passes through two front stages
// (channel max/min and hue sector, then dividend setup), six divider stages
// resolving three quotient bits each (two in the last) for both the
// saturation and hue divisions, and one output register. Each stage stalls
// only when it is full and the stage after it cannot take data, so bubbles are
// squeezed out and up to nine pixels can be in flight. Grey pixels give zero
// hue and saturation.
module rgb8_to_hsv16_converter_core
    import r2h_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t pixel,
    output logic   out_valid,
    input  logic   out_ready,
    output hsv_t   hsv
);

    logic      fe_valid;
    logic      fe_ready;
    div_item_t fe_item;
    logic      dv_valid;
    logic      dv_ready;
    div_item_t dv_item;

    r2h_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pixel     (pixel),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_item  (fe_item)
    );

    r2h_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_item   (fe_item),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_item  (dv_item)
    );

    r2h_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_item   (dv_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_hsv   (hsv)
    );

    a_bright_scale: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hsv.brightness[15:8] == hsv.brightness[7:0])
        else $error("brightness is not max*257");

    a_grey_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hsv.saturation == '0) |-> hsv.hue == '0)
        else $error("nonzero hue on grey pixel");

    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hsv.brightness == '0) |-> hsv.saturation == '0)
        else $error("nonzero saturation on black pixel");

endmodule

### rtl/r2h_front.sv
// Front end: max/min/sector selection, then rounded dividend and divisor setup.
module r2h_front
    import r2h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  pixel_t    pixel,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    localparam int unsigned HNUM_W = 11;  // holds up to 6*255

    logic              s1_valid_reg;
    logic [CH_W-1:0]   s1_mx_reg;
    logic [CH_W-1:0]   s1_d_reg;
    logic [HNUM_W-1:0] s1_hnum_reg;
    logic [CH_W-1:0]   s1_mx_next;
    logic [CH_W-1:0]   s1_d_next;
    logic [HNUM_W-1:0] s1_hnum_next;

    logic              s2_valid_reg;
    div_item_t         s2_item_reg;
    div_item_t         s2_item_next;

    logic              en1;
    logic              en2;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // Stage 1: extremes and hue offset, pre-biased by sector*d
    always_comb
    begin
        logic [CH_W-1:0]   mx;
        logic [CH_W-1:0]   mn;
        logic [HNUM_W-1:0] r11;
        logic [HNUM_W-1:0] g11;
        logic [HNUM_W-1:0] b11;
        logic [HNUM_W-1:0] d11;
        mx = pixel.red;
        mn = pixel.red;
        if (pixel.green > mx) mx = pixel.green;
        if (pixel.blue > mx)  mx = pixel.blue;
        if (pixel.green < mn) mn = pixel.green;
        if (pixel.blue < mn)  mn = pixel.blue;
        r11 = HNUM_W'(pixel.red);
        g11 = HNUM_W'(pixel.green);
        b11 = HNUM_W'(pixel.blue);
        d11 = HNUM_W'(mx - mn);
        s1_mx_next = mx;
        s1_d_next  = mx - mn;
        priority if (mx == pixel.red)
        begin
            if (pixel.green >= pixel.blue)
            begin
                s1_hnum_next = g11 - b11;
            end
            else
            begin
                // negative offset wraps into sector six
                s1_hnum_next = (d11 << 2) + (d11 << 1) - b11 + g11;
            end
        end
        else if (mx == pixel.green)
        begin
            s1_hnum_next = (d11 << 1) + b11 - r11;
        end
        else
        begin
            s1_hnum_next = (d11 << 2) + r11 - g11;
        end
    end

    // Stage 2: round-half-up form (2a+b)/(2b); grey pixels divide 0 by 1
    always_comb
    begin
        logic [NUM_W-1:0] d_ext;
        logic [NUM_W-1:0] mx_ext;
        logic [NUM_W-1:0] hn_ext;
        logic [REM_W-1:0] d_den;
        d_ext  = NUM_W'(s1_d_reg);
        mx_ext = NUM_W'(s1_mx_reg);
        hn_ext = NUM_W'(s1_hnum_reg);
        d_den  = REM_W'(s1_d_reg);
        s2_item_next.mx = s1_mx_reg;
        if (s1_d_reg == '0)
        begin
            s2_item_next.sat = lane_init('0, REM_W'(1));
            s2_item_next.hue = lane_init('0, REM_W'(1));
        end
        else
        begin
            s2_item_next.sat = lane_init(
                (d_ext << (FRAC_W + 1)) - (d_ext << 1) + mx_ext,
                REM_W'({s1_mx_reg, 1'b0}));
            s2_item_next.hue = lane_init(
                (hn_ext << (FRAC_W + 1)) - (hn_ext << 1) + (d_ext << 2) + (d_ext << 1),
                (d_den << 3) + (d_den << 2));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg <= in_valid;
            if (en2) s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_mx_reg   <= s1_mx_next;
            s1_d_reg    <= s1_d_next;
            s1_hnum_reg <= s1_hnum_next;
        end
        if (en2)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

### rtl/r2h_div.sv
// Pipelined restoring divider, saturation and hue lanes side by side.
module r2h_div
    import r2h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output div_item_t out_item
);

    localparam int unsigned LAST = DIV_STAGES - 1;

    div_item_t stage_reg  [DIV_STAGES];
    div_item_t stage_next [DIV_STAGES];
    logic      valid_reg  [DIV_STAGES];
    logic      en         [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        localparam int unsigned LEFT  = DIV_STEPS - s * DIV_STEPS_PER_STAGE;
        localparam int unsigned NSTEP =
            (LEFT < DIV_STEPS_PER_STAGE) ? LEFT : DIV_STEPS_PER_STAGE;

        div_item_t stage_in;
        logic      valid_in;
        logic      ready_down;

        if (s == 0)
        begin : g_first
            assign stage_in = in_item;
            assign valid_in = in_valid;
        end
        else
        begin : g_mid
            assign stage_in = stage_reg[s-1];
            assign valid_in = valid_reg[s-1];
        end

        if (s == LAST)
        begin : g_tail
            assign ready_down = out_ready;
        end
        else
        begin : g_body
            assign ready_down = en[s+1];
        end

        assign en[s] = !valid_reg[s] || ready_down;

        always_comb
        begin
            stage_next[s] = stage_in;
            for (int unsigned k = 0; k < DIV_STEPS_PER_STAGE; k++)
            begin
                if (k < NSTEP)
                begin
                    stage_next[s].sat = div_step(stage_next[s].sat);
                    stage_next[s].hue = div_step(stage_next[s].hue);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en[s])
            begin
                valid_reg[s] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[LAST];
    assign out_item  = stage_reg[LAST];

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (stage_reg[0].sat.den != '0 && stage_reg[0].hue.den != '0))
        else $error("divider entered with zero divisor");

    a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] |-> stage_reg[LAST].sat.rem < stage_reg[LAST].sat.den)
        else $error("saturation remainder not below divisor");

    a_hue_rem: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[LAST] |-> stage_reg[LAST].hue.rem < stage_reg[LAST].hue.den)
        else $error("hue remainder not below divisor");

endmodule

### rtl/r2h_out.sv
// Output register: quotient clamp and brightness scaling.
module r2h_out
    import r2h_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_item_t in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output hsv_t      out_hsv
);

    logic valid_reg;
    hsv_t hsv_reg;
    hsv_t hsv_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        hsv_next.hue        = clamp16(in_item.hue.acc);
        hsv_next.saturation = clamp16(in_item.sat.acc);
        hsv_next.brightness = {in_item.mx, in_item.mx};  // mx * 257
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            hsv_reg <= hsv_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_hsv   = hsv_reg;

endmodule
